@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is held low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked property, checked during reset too.
`define ASSERT_CLK_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ rtl/mpfs_pkg.sv @@
// Types, codes and reset values for the motor power fault supervisor.
// No dependencies; imported by every module of the block.
package mpfs_pkg;

  typedef enum logic [1:0] {
    PM_SLEEP  = 2'd0,
    PM_ACTIVE = 2'd1,
    PM_FAULT  = 2'd2
  } pmode_t;

  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_STATE  = 3'd1;
  localparam logic [2:0] REQ_CLEAR  = 3'd2;
  localparam logic [2:0] REQ_REPORT = 3'd3;
  localparam logic [2:0] REQ_EDGE   = 3'd4;

  localparam logic [1:0] WANT_NONE = 2'd3;

  localparam logic [1:0] CFG_VBUS_MIN  = 2'd0;
  localparam logic [1:0] CFG_RELEASE   = 2'd1;
  localparam logic [1:0] CFG_DRV_CODE  = 2'd2;
  localparam logic [1:0] CFG_UV_CODE   = 2'd3;

  localparam logic [15:0] VBUS_MIN_RST = 16'd8000;
  localparam logic [15:0] RELEASE_RST  = 16'd3000;
  localparam logic [7:0]  DRV_CODE_RST = 8'd1;
  localparam logic [7:0]  UV_CODE_RST  = 8'd2;

  typedef struct packed {
    logic [15:0] vbus_min_mv;
    logic [15:0] release_ms;
    logic [7:0]  drv_code;
    logic [7:0]  undervolt_code;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  wanted_state;
    logic [7:0]  reported_code;
    logic [31:0] now_ms;
    logic        fault_line_low;
    logic        vbus_valid;
    logic [15:0] vbus_mv;
  } item_t;

  typedef struct packed {
    pmode_t      mode;
    logic [7:0]  code;
    logic [31:0] fault_start;
    logic [31:0] transitions;
    logic        edge_pending;
    logic        pin;
    logic        enc;
  } sup_state_t;

  typedef struct packed {
    logic [1:0]  cur_state;
    logic [1:0]  prev_state;
    logic        state_changed;
    logic [7:0]  held_code;
    logic [31:0] transition_count;
    logic        motor_power;
    logic        encoder_continuous;
    logic        driver_fault_event;
    logic        undervolt_event;
  } result_t;

endpackage

@@ rtl/mpfs_if.sv @@
// Request and result channel interfaces of the supervisor.
// Valid/ready handshake; no package dependency.
interface mpfs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [1:0]  wanted_state;
  logic [7:0]  reported_code;
  logic [31:0] now_ms;
  logic        fault_line_low;
  logic        vbus_valid;
  logic [15:0] vbus_mv;

  modport source (output valid, req_type, wanted_state, reported_code, now_ms,
                  fault_line_low, vbus_valid, vbus_mv, input ready);
  modport sink (input valid, req_type, wanted_state, reported_code, now_ms,
                fault_line_low, vbus_valid, vbus_mv, output ready);
endinterface

interface mpfs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cur_state;
  logic [1:0]  prev_state;
  logic        state_changed;
  logic [7:0]  held_code;
  logic [31:0] transition_count;
  logic        motor_power;
  logic        encoder_continuous;
  logic        driver_fault_event;
  logic        undervolt_event;

  modport source (output valid, cur_state, prev_state, state_changed, held_code,
                  transition_count, motor_power, encoder_continuous,
                  driver_fault_event, undervolt_event, input ready);
  modport sink (input valid, cur_state, prev_state, state_changed, held_code,
                transition_count, motor_power, encoder_continuous,
                driver_fault_event, undervolt_event, output ready);
endinterface

@@ rtl/motor_power_fault_supervisor.sv @@
// Motor power fault supervisor: sleep, active and fault states for a driver supply.
// A request is held in the input register, and its result then in the result register.
// One request per cycle while the result channel is not stalled.
// A waiting result stalls the input only once a second request sits in the input register.
// Reset (rst_n low, synchronous) empties both stages, restores configuration
// defaults and puts the supervisor into sleep with the motor unpowered.
module motor_power_fault_supervisor (
  input  logic        clk,
  input  logic        rst_n,
  mpfs_in_if.sink     in_chan,
  mpfs_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import mpfs_pkg::*;

  cfg_t       cfg;
  item_t      in_item;
  item_t      item_r;
  logic       item_valid_r;
  sup_state_t st_r;
  sup_state_t st_nxt;
  result_t    res;
  result_t    res_r;
  logic       out_valid_r;
  logic       advance;

  mpfs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mpfs_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  assign in_item.req_type       = in_chan.req_type;
  assign in_item.wanted_state   = in_chan.wanted_state;
  assign in_item.reported_code  = in_chan.reported_code;
  assign in_item.now_ms         = in_chan.now_ms;
  assign in_item.fault_line_low = in_chan.fault_line_low;
  assign in_item.vbus_valid     = in_chan.vbus_valid;
  assign in_item.vbus_mv        = in_chan.vbus_mv;

  assign advance       = item_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !item_valid_r || advance;

  // hold the request until the result register is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      item_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '{mode: PM_SLEEP, code: 8'd0, fault_start: 32'd0,
                       transitions: 32'd0, edge_pending: 1'b0, pin: 1'b0,
                       enc: 1'b0};
      out_valid_r <= 1'b0;
    end else if (advance) begin
      st_r        <= st_nxt;
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_chan.valid              = out_valid_r;
  assign out_chan.cur_state          = res_r.cur_state;
  assign out_chan.prev_state         = res_r.prev_state;
  assign out_chan.state_changed      = res_r.state_changed;
  assign out_chan.held_code          = res_r.held_code;
  assign out_chan.transition_count   = res_r.transition_count;
  assign out_chan.motor_power        = res_r.motor_power;
  assign out_chan.encoder_continuous = res_r.encoder_continuous;
  assign out_chan.driver_fault_event = res_r.driver_fault_event;
  assign out_chan.undervolt_event    = res_r.undervolt_event;

endmodule

@@ rtl/mpfs_cfg.sv @@
// Configuration register file of the supervisor.
// Depends on mpfs_pkg for register indexes and reset values.
module mpfs_cfg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_wdata,
  output mpfs_pkg::cfg_t cfg
);
  import mpfs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vbus_min_mv    <= VBUS_MIN_RST;
      cfg_r.release_ms     <= RELEASE_RST;
      cfg_r.drv_code       <= DRV_CODE_RST;
      cfg_r.undervolt_code <= UV_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VBUS_MIN: cfg_r.vbus_min_mv    <= cfg_wdata;
        CFG_RELEASE:  cfg_r.release_ms     <= cfg_wdata;
        CFG_DRV_CODE: cfg_r.drv_code       <= cfg_wdata[7:0];
        CFG_UV_CODE:  cfg_r.undervolt_code <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/mpfs_step.sv @@
// Next-state and result logic for one request of the supervisor.
// Depends on mpfs_pkg for the state, item, config and result types.
module mpfs_step (
  input  mpfs_pkg::cfg_t       cfg,
  input  mpfs_pkg::sup_state_t st,
  input  mpfs_pkg::item_t      item,
  output mpfs_pkg::sup_state_t st_nxt,
  output mpfs_pkg::result_t    res
);
  import mpfs_pkg::*;

  sup_state_t  s;
  pmode_t      tgt;
  logic        go;
  logic        changed;
  logic        ev_drv;
  logic        ev_uv;
  logic [31:0] elapsed;
  logic        undervolt;

  assign elapsed   = item.now_ms - st.fault_start;
  assign undervolt = item.vbus_valid && (item.vbus_mv != 16'd0) &&
                     (item.vbus_mv < cfg.vbus_min_mv);

  always_comb begin
    s      = st;
    tgt    = st.mode;
    go     = 1'b0;
    ev_drv = 1'b0;
    ev_uv  = 1'b0;
    unique case (item.req_type)
      REQ_TICK: begin
        s.edge_pending = 1'b0;
        if (st.edge_pending && st.mode != PM_FAULT) begin
          s.code = cfg.drv_code;
          go     = 1'b1;
          tgt    = PM_FAULT;
          ev_drv = 1'b1;
        end else if (st.mode == PM_FAULT) begin
          if (!item.fault_line_low) begin
            if (elapsed > {16'd0, cfg.release_ms}) begin
              s.code = 8'd0;
              go     = 1'b1;
              tgt    = PM_SLEEP;
            end
          end else begin
            s.fault_start = item.now_ms;
          end
        end else if (st.mode == PM_ACTIVE && undervolt) begin
          s.code = cfg.undervolt_code;
          go     = 1'b1;
          tgt    = PM_FAULT;
          ev_uv  = 1'b1;
        end
      end
      REQ_STATE: begin
        if (item.wanted_state != WANT_NONE && st.mode != PM_FAULT) begin
          go  = 1'b1;
          tgt = pmode_t'(item.wanted_state);
        end
      end
      REQ_CLEAR: begin
        s.code = 8'd0;
        if (st.mode == PM_FAULT) begin
          go  = 1'b1;
          tgt = PM_SLEEP;
        end
      end
      REQ_REPORT: begin
        s.code = (item.reported_code == 8'd0) ? cfg.drv_code
                                              : item.reported_code;
        go  = 1'b1;
        tgt = PM_FAULT;
      end
      REQ_EDGE: begin
        s.pin          = 1'b0;
        s.edge_pending = 1'b1;
      end
      default: ;
    endcase

    changed = go && (tgt != st.mode);
    if (changed) begin
      s.mode        = tgt;
      s.transitions = st.transitions + 32'd1;
      unique case (tgt)
        PM_SLEEP: begin
          s.pin = 1'b0;
          s.enc = 1'b0;
        end
        PM_ACTIVE: begin
          s.pin = 1'b1;
          s.enc = 1'b1;
        end
        PM_FAULT: begin
          s.pin         = 1'b0;
          s.fault_start = item.now_ms;
        end
        default: ;
      endcase
    end
  end

  assign st_nxt = s;

  assign res.cur_state          = s.mode;
  assign res.prev_state         = st.mode;
  assign res.state_changed      = changed;
  assign res.held_code          = s.code;
  assign res.transition_count   = s.transitions;
  assign res.motor_power        = s.pin;
  assign res.encoder_continuous = s.enc;
  assign res.driver_fault_event = ev_drv;
  assign res.undervolt_event    = ev_uv;

endmodule

@@ rtl/mpfs_checker.sv @@
// Port-level checks on the supervisor result channel, bound to the top level.
// Depends on mpfs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mpfs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] cur_state,
  input logic [1:0] prev_state,
  input logic       state_changed,
  input logic       motor_power,
  input logic       driver_fault_event,
  input logic       undervolt_event
);
  import mpfs_pkg::*;

  `ASSERT_CLK_ALL(a_reset_empties, clk, !rst_n |=> !out_valid)
  `ASSERT_CLK(a_stall_holds, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `ASSERT_CLK(a_power_only_active, clk, rst_n,
    out_valid && motor_power |-> cur_state == PM_ACTIVE)
  `ASSERT_CLK(a_change_moves, clk, rst_n,
    out_valid && state_changed |-> cur_state != prev_state)
  `ASSERT_CLK(a_event_enters_fault, clk, rst_n,
    out_valid && (driver_fault_event || undervolt_event) |->
      state_changed && cur_state == PM_FAULT)

endmodule

bind motor_power_fault_supervisor mpfs_checker u_mpfs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .cur_state          (out_chan.cur_state),
  .prev_state         (out_chan.prev_state),
  .state_changed      (out_chan.state_changed),
  .motor_power        (out_chan.motor_power),
  .driver_fault_event (out_chan.driver_fault_event),
  .undervolt_event    (out_chan.undervolt_event)
);
